// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and control/status types of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;

  // Shortest legal frame: header, length, checksum and one payload word
  localparam int MIN_FRAME = 8;

  // Header register indexes on the configuration port
  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  // Input item kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;        // input beat accepted: advance the parser
    logic load_first;  // load word 0 of a good frame into the output register
    logic load_next;   // load the next word of the run
    logic pop;         // output beat taken
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_valid;   // output register holds a beat
    logic ev_err;      // current input beat ends in an error result
    logic ev_good;     // current input beat completes a good frame
    logic next_last;   // the next word of the run is the final one
  } stat_t;

endpackage

// ===== rtl/sfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the deframer: received items in, results out.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [sfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sfd_pkg::STATUS_W-1:0] status;
  logic [sfd_pkg::INDEX_W-1:0]  field_index;
  logic [sfd_pkg::WORD_W-1:0]   field_value;
  logic                         last;

  modport source (output valid, output status, output field_index, output field_value,
                  output last, input ready);
  modport sink   (input valid, input status, input field_index, input field_value,
                  input last, output ready);
endinterface

// ===== rtl/sfd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl
// Handshake controller: accepts input beats and sequences the word run.
// ----------------------------------------------------------------------------
module sfd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  input  sfd_pkg::stat_t  stat_i,
  output sfd_pkg::cmd_t   cmd_o,
  input  logic            multi_word_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic accept, take;

  // Take an input beat only when idle and the output slot frees up
  assign in_ready_o = (state_q == ST_IDLE) && (!stat_i.out_valid || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign take       = stat_i.out_valid && out_ready_i;

  always_comb begin
    cmd_o.step       = accept;
    cmd_o.load_first = accept && stat_i.ev_good;
    cmd_o.load_next  = (state_q == ST_EMIT) && take;
    cmd_o.pop        = take;
  end

  // Stay in the run until the final word is loaded
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load_first && multi_word_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.load_next && stat_i.next_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sfd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_datapath
// Frame parser state, byte sum, word store and the registered output beat.
// ----------------------------------------------------------------------------
module sfd_datapath #(
  parameter int MAX_FRAME   = 64,
  parameter int FIELD_COUNT = 19
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata_i,
  input  logic                          in_kind_i,
  input  logic [sfd_pkg::BYTE_W-1:0]    in_byte_i,
  input  sfd_pkg::cmd_t                 cmd_i,
  output sfd_pkg::stat_t                stat_o,
  output logic [sfd_pkg::STATUS_W-1:0]  out_status_o,
  output logic [sfd_pkg::INDEX_W-1:0]   out_index_o,
  output logic [sfd_pkg::WORD_W-1:0]    out_value_o,
  output logic                          out_last_o
);

  localparam int LEN_BITS = $clog2(MAX_FRAME + 1);
  localparam int POS_W    = (LEN_BITS > 6) ? LEN_BITS : 6;
  localparam int IDX_W    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
  localparam int BW       = sfd_pkg::BYTE_W;
  localparam int WW       = sfd_pkg::WORD_W;

  localparam logic [2:0] PH_HUNT1  = 3'd0;
  localparam logic [2:0] PH_HUNT2  = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;

  logic [BW-1:0]    hdr_first_q, hdr_second_q;
  logic [2:0]       phase_q, phase_d;
  logic [POS_W-1:0] len_q, len_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [WW-1:0]    sum_q, sum_d;
  logic [BW-1:0]    hold_q, hold_d;
  logic [WW-1:0]    store_q [FIELD_COUNT];

  logic [WW-1:0]    wide_val;
  logic [POS_W-1:0] off;
  logic             wr_en, wr_hi, clr;
  logic [IDX_W-1:0] wr_word;
  logic             ev_err, ev_good;
  logic             err_load;
  logic [sfd_pkg::STATUS_W-1:0] err_code;

  logic             out_valid_q;
  logic [IDX_W-1:0] cnt_q;
  logic [IDX_W-1:0] cnt_inc;
  logic [IDX_W-1:0] rd_idx;
  logic             next_last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= 8'h2D;
      hdr_second_q <= 8'h23;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::CFG_HEADER_FIRST:  hdr_first_q  <= cfg_wdata_i;
        sfd_pkg::CFG_HEADER_SECOND: hdr_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Evaluate the offered input beat; state advances only when it is accepted
  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    hold_d   = hold_q;
    wr_en    = 1'b0;
    wr_hi    = 1'b0;
    clr      = 1'b0;
    ev_err   = 1'b0;
    ev_good  = 1'b0;
    err_code = sfd_pkg::STATUS_TIMEOUT;
    wide_val = {in_byte_i, hold_q};
    off      = pos_q - POS_W'(4);
    wr_word  = off[IDX_W:1];
    if (in_kind_i == sfd_pkg::KIND_TIMEOUT) begin
      phase_d = PH_HUNT1;
      if (phase_q != PH_HUNT1 && phase_q != PH_HUNT2) begin
        ev_err   = 1'b1;
        err_code = sfd_pkg::STATUS_TIMEOUT;
      end
    end else begin
      case (phase_q)
        PH_HUNT1: begin
          if (in_byte_i == hdr_first_q) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (in_byte_i == hdr_second_q) begin
            clr     = 1'b1;
            sum_d   = {8'h00, hdr_first_q} + {8'h00, hdr_second_q};
            pos_d   = POS_W'(2);
            phase_d = PH_LEN_LO;
          end else if (in_byte_i == hdr_first_q) begin
            phase_d = PH_HUNT2;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LEN_LO: begin
          hold_d  = in_byte_i;
          sum_d   = sum_q + {8'h00, in_byte_i};
          pos_d   = POS_W'(3);
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_d = sum_q + {8'h00, in_byte_i};
          if (wide_val < WW'(sfd_pkg::MIN_FRAME) || wide_val > WW'(MAX_FRAME)) begin
            ev_err   = 1'b1;
            err_code = sfd_pkg::STATUS_BAD_LEN;
            phase_d  = PH_HUNT1;
          end else begin
            len_d   = wide_val[POS_W-1:0];
            pos_d   = POS_W'(4);
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (pos_q < len_q - POS_W'(2)) begin
            // Payload byte: sum it, store it while inside the word store
            sum_d = sum_q + {8'h00, in_byte_i};
            pos_d = pos_q + POS_W'(1);
            if (off < POS_W'(2 * FIELD_COUNT)) begin
              wr_en = 1'b1;
              wr_hi = off[0];
            end
          end else if (pos_q == len_q - POS_W'(2)) begin
            hold_d = in_byte_i;
            pos_d  = pos_q + POS_W'(1);
          end else begin
            // Checksum high byte closes the frame
            phase_d = PH_HUNT1;
            pos_d   = pos_q + POS_W'(1);
            if (wide_val == sum_q) begin
              ev_good = 1'b1;
            end else begin
              ev_err   = 1'b1;
              err_code = sfd_pkg::STATUS_BAD_SUM;
            end
          end
        end
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

  assign err_load = cmd_i.step && ev_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      len_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
    end else if (cmd_i.step) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
    end
  end

  // Word store: clear at header, write payload bytes by lane
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && clr) begin
      for (int k = 0; k < FIELD_COUNT; k++) begin
        store_q[k] <= '0;
      end
    end else if (cmd_i.step && wr_en) begin
      if (wr_hi) begin
        store_q[wr_word][WW-1:BW] <= in_byte_i;
      end else begin
        store_q[wr_word][BW-1:0] <= in_byte_i;
      end
    end
  end

  // Output register and run counter
  assign cnt_inc   = cnt_q + IDX_W'(1);
  assign rd_idx    = cmd_i.load_next ? cnt_inc : '0;
  assign next_last = ({1'b0, cnt_q} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(FIELD_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (err_load || cmd_i.load_first || cmd_i.load_next) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.pop) begin
        out_valid_q <= 1'b0;
      end
      if (err_load || cmd_i.load_first) begin
        cnt_q <= '0;
      end else if (cmd_i.load_next) begin
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_load) begin
      out_status_o <= err_code;
      out_value_o  <= '0;
      out_last_o   <= 1'b1;
    end else if (cmd_i.load_first) begin
      out_status_o <= sfd_pkg::STATUS_GOOD;
      out_value_o  <= store_q[rd_idx];
      out_last_o   <= (FIELD_COUNT == 1);
    end else if (cmd_i.load_next) begin
      out_status_o <= sfd_pkg::STATUS_GOOD;
      out_value_o  <= store_q[rd_idx];
      out_last_o   <= next_last;
    end
  end

  assign out_index_o = sfd_pkg::INDEX_W'(cnt_q);

  always_comb begin
    stat_o.out_valid = out_valid_q;
    stat_o.ev_err    = ev_err;
    stat_o.ev_good   = ev_good;
    stat_o.next_last = next_last;
  end

endmodule

// ===== rtl/sensor_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_core
// Hunts for a two-byte header in a UART byte stream, checks length and
// checksum, and emits the payload words of each good frame as one run.
//
// in_ch carries one beat per received byte (kind 0) or receive gap
// timeout (kind 1). out_ch carries result beats: one error beat for a bad
// length, checksum mismatch or mid-frame timeout, or FIELD_COUNT word beats
// for a good frame, with last set on the final beat of each run.
// A result appears in the output register the cycle after the input beat
// that causes it. A good frame streams one word per cycle from the word
// store while out_ch is ready, and in_ch is held off after the closing
// checksum byte until the final word of the run is loaded. While out_ch
// stalls with a beat pending, in_ch.ready stays low.
// Reset returns the parser to the header hunt, loads the header registers
// with 0x2D and 0x23 and empties the output register. The header registers
// are written through cfg_we_i, cfg_idx_i (0 first, 1 second), cfg_wdata_i.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_core #(
  parameter int MAX_FRAME   = 64,
  parameter int FIELD_COUNT = 19
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfd_in_if.sink                     in_ch,
  sfd_out_if.source                  out_ch,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sfd_pkg::BYTE_W-1:0] cfg_wdata_i
);

  sfd_pkg::cmd_t  cmd;
  sfd_pkg::stat_t stat;

  // Handshake and run sequencing
  sfd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .out_ready_i  (out_ch.ready),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .multi_word_i (FIELD_COUNT > 1)
  );

  // Parser, word store and output register
  sfd_datapath #(
    .MAX_FRAME   (MAX_FRAME),
    .FIELD_COUNT (FIELD_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_kind_i    (in_ch.kind),
    .in_byte_i    (in_ch.rx_byte),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status_o (out_ch.status),
    .out_index_o  (out_ch.field_index),
    .out_value_o  (out_ch.field_value),
    .out_last_o   (out_ch.last)
  );

  assign out_ch.valid = stat.out_valid;

  // Accept input only when the output slot is free or draining
  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |-> !out_ch.valid || out_ch.ready)
    else $error("input beat accepted while a result was stalled");

  // A run continues in the next cycle with the next index
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      out_ch.valid && out_ch.field_index == sfd_pkg::INDEX_W'($past(out_ch.field_index) + 1'b1))
    else $error("word run broken");

  // Error beats stand alone
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.status != sfd_pkg::STATUS_GOOD |-> out_ch.last)
    else $error("error result without last");

  // No input is taken in the middle of a run
  a_run_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("input accepted during a word run");

endmodule

// ===== tb/sv/tb_sensor_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_core
// Self-checking bench for the sensor frame deframer. A queue of received
// bytes and gap timeouts feeds a clocked driver; a monitor parses every
// accepted input beat with an in-bench frame parser and checks every result
// beat against the oldest predicted word or error. Several header settings
// are exercised, with random idle gaps on both channels and a long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_core;

  localparam int MAX_FRAME   = 64;
  localparam int FIELD_COUNT = 19;
  localparam int CLK_HALF    = 10;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    LEN_LOW,
    LEN_HIGH,
    BODY
  } parse_phase_e;

  typedef struct packed {
    logic                       kind;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [sfd_pkg::STATUS_W-1:0] status;
    logic [sfd_pkg::INDEX_W-1:0]  field_index;
    logic [sfd_pkg::WORD_W-1:0]   field_value;
    logic                         last;
  } frame_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [sfd_pkg::BYTE_W-1:0] cfg_wdata_i;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  sensor_frame_deframer_core #(
    .MAX_FRAME   (MAX_FRAME),
    .FIELD_COUNT (FIELD_COUNT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Parser copy: header settings and frame state
  logic [sfd_pkg::BYTE_W-1:0] hdr_first;
  logic [sfd_pkg::BYTE_W-1:0] hdr_second;
  parse_phase_e      ph;
  logic [15:0]       frm_len;
  logic [15:0]       byte_pos;
  logic [15:0]       sum;
  logic [7:0]        lo_hold;
  logic [15:0]       field_words [FIELD_COUNT];

  rx_item_t      rx_backlog[$];
  frame_result_t pending_results[$];

  int  n_queued;
  int  n_in_beats;
  int  n_out_beats;
  int  n_errors;
  int  n_good_frames;
  int  n_status [4];
  int  n_settings;
  bit  in_took;
  int  in_gap;
  int  out_gap;
  bit  calm;
  bit  hold_off;
  bit  holdoff_armed;
  int  holdoff_at;

  // Clock and reset
  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = sfd_pkg::CFG_HEADER_FIRST;
    cfg_wdata_i = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = sfd_pkg::KIND_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_error(logic [sfd_pkg::STATUS_W-1:0] st);
    frame_result_t res;
    ph = HUNT_FIRST;
    res = '{status: st, field_index: '0, field_value: '0, last: 1'b1};
    pending_results.push_back(res);
    n_status[st]++;
  endfunction

  // Advance the frame parser by one accepted beat and predict its results
  function automatic void parse_rx_beat(logic kind, logic [sfd_pkg::BYTE_W-1:0] b);
    int            off;
    frame_result_t res;
    if (kind == sfd_pkg::KIND_TIMEOUT) begin
      if (ph == HUNT_FIRST || ph == HUNT_SECOND) begin
        ph = HUNT_FIRST;
      end else begin
        push_error(sfd_pkg::STATUS_TIMEOUT);
      end
      return;
    end
    case (ph)
      HUNT_FIRST: begin
        if (b == hdr_first) ph = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == hdr_second) begin
          foreach (field_words[k]) field_words[k] = '0;
          sum      = 16'(hdr_first) + 16'(hdr_second);
          byte_pos = 16'd2;
          ph       = LEN_LOW;
        end else if (b == hdr_first) begin
          ph = HUNT_SECOND;
        end else begin
          ph = HUNT_FIRST;
        end
      end
      LEN_LOW: begin
        lo_hold  = b;
        sum      = sum + 16'(b);
        byte_pos = 16'd3;
        ph       = LEN_HIGH;
      end
      LEN_HIGH: begin
        frm_len = {b, lo_hold};
        sum     = sum + 16'(b);
        if (frm_len < sfd_pkg::MIN_FRAME || frm_len > MAX_FRAME) begin
          push_error(sfd_pkg::STATUS_BAD_LEN);
        end else begin
          byte_pos = 16'd4;
          ph       = BODY;
        end
      end
      BODY: begin
        if (byte_pos < frm_len - 16'd2) begin
          // Sum every payload byte, store only what fits in the word store
          sum = sum + 16'(b);
          off = int'(byte_pos) - 4;
          if (off < 2 * FIELD_COUNT) begin
            if (off % 2 == 1) field_words[off / 2][15:8] = b;
            else              field_words[off / 2][7:0]  = b;
          end
          byte_pos = byte_pos + 16'd1;
        end else if (byte_pos == frm_len - 16'd2) begin
          lo_hold  = b;
          byte_pos = byte_pos + 16'd1;
        end else begin
          byte_pos = byte_pos + 16'd1;
          if ({b, lo_hold} != sum) begin
            push_error(sfd_pkg::STATUS_BAD_SUM);
          end else begin
            ph = HUNT_FIRST;
            for (int k = 0; k < FIELD_COUNT; k++) begin
              res = '{status: sfd_pkg::STATUS_GOOD, field_index: sfd_pkg::INDEX_W'(k),
                      field_value: field_words[k], last: (k == FIELD_COUNT - 1)};
              pending_results.push_back(res);
            end
            n_status[sfd_pkg::STATUS_GOOD]++;
            n_good_frames++;
          end
        end
      end
      default: ph = HUNT_FIRST;
    endcase
  endfunction

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    frame_result_t exp_res;
    in_took = 1'b0;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        n_in_beats++;
        parse_rx_beat(in_ch.kind, in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out_beats++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("[%0t] unexpected result: status %0d index %0d value %h last %0b",
                     $realtime, out_ch.status, out_ch.field_index, out_ch.field_value,
                     out_ch.last);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_ch.status !== exp_res.status ||
              out_ch.field_index !== exp_res.field_index ||
              out_ch.field_value !== exp_res.field_value ||
              out_ch.last !== exp_res.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"[%0t] mismatch: expected status %0d index %0d value %h last %0b,",
                        " got status %0d index %0d value %h last %0b"},
                       $realtime, exp_res.status, exp_res.field_index,
                       exp_res.field_value, exp_res.last, out_ch.status,
                       out_ch.field_index, out_ch.field_value, out_ch.last);
          end
        end
      end
    end
  end

  // Input driver: hold the beat until taken, then gap or offer the next one
  always @(negedge clk_i) begin
    rx_item_t it;
    logic     nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_ch.valid && !in_took;
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (rx_backlog.size() > 0) begin
          it = rx_backlog.pop_front();
          nxt_valid = 1'b1;
          in_ch.kind    <= it.kind;
          in_ch.rx_byte <= it.rx_byte;
          in_gap = pick_gap();
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // Output ready: random stalls, or a forced hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Long hold-off while the sender keeps offering beats
  initial begin
    hold_off = 1'b0;
    holdoff_armed = 1'b0;
    while (!(holdoff_armed && n_in_beats >= holdoff_at)) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end

  task automatic queue_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    rx_backlog.push_back('{kind: sfd_pkg::KIND_BYTE, rx_byte: b});
    n_queued++;
  endtask

  task automatic queue_timeout();
    rx_backlog.push_back('{kind: sfd_pkg::KIND_TIMEOUT,
                           rx_byte: sfd_pkg::BYTE_W'($urandom_range(0, 255))});
    n_queued++;
  endtask

  // Build a frame with the current header; fill < 0 gives random payload.
  // cut_at >= 0 replaces the byte at that position and the rest by a timeout.
  task automatic queue_frame(input int pay_n, input int fill, input bit bad_sum,
                             input int cut_at);
    logic [7:0]  fb[$];
    logic [15:0] len;
    logic [15:0] s;
    len = 16'(pay_n + 6);
    s   = '0;
    fb.push_back(hdr_first);
    fb.push_back(hdr_second);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    for (int i = 0; i < pay_n; i++)
      fb.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    foreach (fb[i]) s = s + 16'(fb[i]);
    if (bad_sum) s = s ^ (16'd1 << $urandom_range(0, 15));
    fb.push_back(s[7:0]);
    fb.push_back(s[15:8]);
    foreach (fb[i]) begin
      if (i == cut_at) begin
        queue_timeout();
        return;
      end
      queue_byte(fb[i]);
    end
  endtask

  task automatic queue_bad_length(input logic [15:0] len);
    queue_byte(hdr_first);
    queue_byte(hdr_second);
    queue_byte(len[7:0]);
    queue_byte(len[15:8]);
  endtask

  // Write one header register; only called while the block is idle
  task automatic write_header(input logic idx, input logic [sfd_pkg::BYTE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == sfd_pkg::CFG_HEADER_FIRST) hdr_first = val;
    else                                  hdr_second = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_headers(input logic [sfd_pkg::BYTE_W-1:0] first,
                             input logic [sfd_pkg::BYTE_W-1:0] second);
    write_header(sfd_pkg::CFG_HEADER_FIRST, first);
    write_header(sfd_pkg::CFG_HEADER_SECOND, second);
    n_settings++;
  endtask

  // Wait until every queued beat is taken and every result has come
  task automatic drain();
    while (!(n_in_beats == n_queued && pending_results.size() == 0 && !in_ch.valid))
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random mix of frames, broken frames and noise
  task automatic queue_random_mix(input int n_items);
    int target;
    int r;
    int pay_n;
    target = n_queued + n_items;
    while (n_queued < target) begin
      r     = $urandom_range(0, 99);
      pay_n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_FRAME - 6)
                                          : $urandom_range(2, 16);
      if (r < 58) begin
        queue_frame(pay_n, -1, 1'b0, -1);
      end else if (r < 68) begin
        queue_frame(pay_n, -1, 1'b1, -1);
      end else if (r < 78) begin
        queue_frame(pay_n, -1, 1'b0, $urandom_range(1, pay_n + 5));
      end else if (r < 86) begin
        if ($urandom_range(0, 1))
          queue_bad_length(16'($urandom_range(0, sfd_pkg::MIN_FRAME - 1)));
        else queue_bad_length(16'($urandom_range(MAX_FRAME + 1, 65535)));
      end else if (r < 94) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) queue_byte(hdr_first);
      end else begin
        queue_timeout();
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    hdr_first  = 8'h2D;
    hdr_second = 8'h23;
    ph         = HUNT_FIRST;
    frm_len    = '0;
    byte_pos   = '0;
    sum        = '0;
    lo_hold    = '0;
    foreach (field_words[k]) field_words[k] = '0;
    calm = 1'b0;
    in_gap  = 0;
    out_gap = 0;
    n_settings = 1;
    while (!rst_ni) @(negedge clk_i);

    // Reset headers: hunt corners, minimum frame, both length bounds, errors
    queue_timeout();
    queue_byte(8'h2D);
    queue_byte(8'h2D);
    queue_byte(8'h11);
    queue_byte(8'h2D);
    queue_timeout();
    queue_byte(8'h2D);
    queue_frame(2, 8'hFF, 1'b0, -1);
    queue_frame(3, -1, 1'b1, -1);
    queue_bad_length(16'd7);
    queue_bad_length(16'd65);
    queue_frame(4, -1, 1'b0, 2);
    drain();

    // Extreme headers, no idling: longest frame fills the store and runs past
    // it, then a timeout at payload start
    calm = 1'b1;
    set_headers(8'hFF, 8'h00);
    queue_frame(MAX_FRAME - 6, -1, 1'b0, -1);
    queue_frame(5, -1, 1'b0, 4);
    drain();
    calm = 1'b0;

    // Equal header bytes
    set_headers(8'h5A, 8'h5A);
    queue_frame(2, -1, 1'b0, -1);
    drain();

    // Random headers and random mix, with a long output hold-off
    set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    holdoff_at = n_in_beats + 4;
    holdoff_armed = 1'b1;
    queue_random_mix(14);
    drain();

    repeat (FIELD_COUNT + 20) @(negedge clk_i);
    if (pending_results.size() != 0) n_errors++;
    $display("Covered %0d input beats and %0d result beats over %0d header settings.",
             n_in_beats, n_out_beats, n_settings);
    $display("Frames: %0d good, %0d bad length, %0d checksum errors, %0d timeouts.",
             n_status[sfd_pkg::STATUS_GOOD], n_status[sfd_pkg::STATUS_BAD_LEN],
             n_status[sfd_pkg::STATUS_BAD_SUM], n_status[sfd_pkg::STATUS_TIMEOUT]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors", n_errors);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
